### sv/mtg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mtg_pkg;

  localparam int unsigned STATE_WORDS  = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned IDX_W        = $clog2(STATE_WORDS + 1);
  localparam int unsigned ADDR_W       = $clog2(STATE_WORDS);
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned HALF_W       = WORD_W / 2;

  localparam logic [WORD_W-1:0] LCG_MULT     = 32'd69069;
  localparam logic [WORD_W-1:0] LCG_INC      = 32'h0000_0001;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

  localparam logic ACT_SEED = 1'b0;
  localparam logic ACT_NEXT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_HI,
    ST_SEED_LO,
    ST_TW_LOAD,
    ST_TW_READ,
    ST_TW_WRITE,
    ST_FETCH,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic seed_load;
    logic seed_hi;
    logic seed_write;
    logic rd_idx;
    logic twist_read;
    logic twist_write;
    logic emit;
    logic idx_clr;
    logic idx_inc;
    logic idx_full;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic idx_wrap;
    logic out_free;
  } status_t;

  function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

### sv/mtg_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mtg_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [mtg_pkg::WORD_W-1:0] seed;

  modport source (output valid, action, seed, input ready);
  modport sink   (input valid, action, seed, output ready);
endinterface

interface mtg_out_if;
  logic                       valid;
  logic                       ready;
  logic [mtg_pkg::WORD_W-1:0] random_word;

  modport source (output valid, random_word, input ready);
  modport sink   (input valid, random_word, output ready);
endinterface

`default_nettype wire

### sv/mtg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mtg_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_action_i,
  output logic                  in_ready_o,
  input  wire mtg_pkg::status_t status_i,
  output mtg_pkg::cmd_t         cmd_o
);

  mtg_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mtg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_action_i == mtg_pkg::ACT_SEED) begin
            cmd_o.seed_load = 1'b1;
            cmd_o.idx_clr   = 1'b1;
            state_d         = mtg_pkg::ST_SEED_HI;
          end else if (status_i.idx_wrap) begin
            cmd_o.idx_clr = 1'b1;
            state_d       = mtg_pkg::ST_TW_LOAD;
          end else begin
            state_d = mtg_pkg::ST_FETCH;
          end
        end
      end
      mtg_pkg::ST_SEED_HI: begin
        cmd_o.seed_hi = 1'b1;
        state_d       = mtg_pkg::ST_SEED_LO;
      end
      mtg_pkg::ST_SEED_LO: begin
        cmd_o.seed_write = 1'b1;
        if (status_i.idx_last) begin
          cmd_o.idx_full = 1'b1;
          state_d        = mtg_pkg::ST_IDLE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = mtg_pkg::ST_SEED_HI;
        end
      end
      mtg_pkg::ST_TW_LOAD: begin
        // prime the word carried into the first twist step
        cmd_o.rd_idx = 1'b1;
        state_d      = mtg_pkg::ST_TW_READ;
      end
      mtg_pkg::ST_TW_READ: begin
        cmd_o.twist_read = 1'b1;
        state_d          = mtg_pkg::ST_TW_WRITE;
      end
      mtg_pkg::ST_TW_WRITE: begin
        cmd_o.twist_write = 1'b1;
        if (status_i.idx_last) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = mtg_pkg::ST_FETCH;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = mtg_pkg::ST_TW_READ;
        end
      end
      mtg_pkg::ST_FETCH: begin
        cmd_o.rd_idx = 1'b1;
        state_d      = mtg_pkg::ST_EMIT;
      end
      mtg_pkg::ST_EMIT: begin
        // hold the fetched word until the output register frees up
        if (status_i.out_free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.idx_inc = 1'b1;
          state_d       = mtg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mtg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/mtg_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mtg_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [mtg_pkg::WORD_W-1:0] seed_i,
  input  wire mtg_pkg::cmd_t              cmd_i,
  output mtg_pkg::status_t                status_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [mtg_pkg::WORD_W-1:0]      out_word_o
);

  localparam int unsigned IdxW  = mtg_pkg::IDX_W;
  localparam int unsigned AddrW = mtg_pkg::ADDR_W;
  localparam int unsigned WordW = mtg_pkg::WORD_W;
  localparam int unsigned HalfW = mtg_pkg::HALF_W;
  localparam int unsigned Depth = mtg_pkg::STATE_WORDS;
  localparam int unsigned Back  = mtg_pkg::STATE_WORDS - mtg_pkg::TWIST_OFFSET;

  logic [WordW-1:0] mem [Depth];

  logic [IdxW-1:0]  idx_q, idx_d;
  logic [WordW-1:0] x_q;
  logic [HalfW-1:0] hi_q;
  logic [WordW-1:0] rd0_q, rd1_q, cur_q;
  logic [WordW-1:0] out_word_q;
  logic             out_valid_q;

  logic [AddrW-1:0] k_addr, nxt_addr, far_addr, rd0_addr, wr_addr;
  logic [WordW-1:0] y, twist_word, wr_data, lcg_next;
  logic             wr_en, rd0_en;

  assign k_addr   = idx_q[AddrW-1:0];
  assign nxt_addr = (k_addr == AddrW'(Depth - 1)) ? '0 : k_addr + AddrW'(1);
  assign far_addr = (k_addr >= AddrW'(Back)) ? k_addr - AddrW'(Back)
                                             : k_addr + AddrW'(mtg_pkg::TWIST_OFFSET);

  assign status_o.idx_last = (idx_q == IdxW'(Depth - 1));
  assign status_o.idx_wrap = (idx_q >= IdxW'(Depth));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign lcg_next = WordW'(x_q * mtg_pkg::LCG_MULT) + mtg_pkg::LCG_INC;

  assign y          = {cur_q[WordW-1], rd0_q[WordW-2:0]};
  assign twist_word = rd1_q ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_MATRIX : '0);

  assign wr_en   = cmd_i.seed_write || cmd_i.twist_write;
  assign wr_addr = k_addr;
  assign wr_data = cmd_i.seed_write ? {hi_q, x_q[WordW-1:HalfW]} : twist_word;

  assign rd0_en   = cmd_i.rd_idx || cmd_i.twist_read;
  assign rd0_addr = cmd_i.twist_read ? nxt_addr : k_addr;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_full) begin
      idx_d = IdxW'(Depth);
    end else if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= IdxW'(Depth);
      out_valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // LCG runs one step per cycle while seeding; upper half latched every other step
  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_load) begin
      x_q <= seed_i;
    end else if (cmd_i.seed_hi || cmd_i.seed_write) begin
      x_q <= lcg_next;
    end
    if (cmd_i.seed_hi) begin
      hi_q <= x_q[WordW-1:HalfW];
    end
    if (cmd_i.twist_read) begin
      cur_q <= rd0_q;
    end
    if (cmd_i.emit) begin
      out_word_q <= mtg_pkg::temper(rd0_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd0_en) begin
      rd0_q <= mem[rd0_addr];
    end
    if (cmd_i.twist_read) begin
      rd1_q <= mem[far_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

### sv/mersenne_twister_generator_unit.sv
// Channel   Dir  Payload                         Beat
// in_i      in   action (1b), seed (32b)         valid && ready
// out_o     out  random_word (32b)               valid && ready
//
// A seed beat runs one LCG multiply per cycle and builds each state word from two LCG steps.
// A next beat passes the fetch and emit states; the first after a seed and every 624th
// after it also runs the twist first, a load step and then a read and a write step per
// state word, on the state memory (one write port, two registered read ports).
// Reset leaves the index at 624; the state memory is not cleared, so seed first.
// in_i.ready is high only in idle; a finished word waits in the output register
// while the next beat is accepted.
`timescale 1ns / 1ps
`default_nettype none

module mersenne_twister_generator_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mtg_in_if.sink     in_i,
  mtg_out_if.source  out_o
);

  mtg_pkg::cmd_t    cmd;
  mtg_pkg::status_t status;

  mtg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mtg_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (in_i.seed),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_o.random_word)
  );

endmodule

`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import mtg_pkg::*;

  localparam int unsigned TAIL_CYCLES  = 1300;
  localparam int unsigned LONG_RUN     = 700;
  localparam int unsigned TARGET_BEATS = 1400;
  localparam int unsigned MAX_REPORTS  = 100;

  typedef struct {
    logic              action;
    logic [WORD_W-1:0] seed;
    bit                drain;
  } beat_t;

  logic clk_i;
  logic rst_ni;

  mtg_in_if  in_if ();
  mtg_out_if out_if ();

  mersenne_twister_generator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // predictor state
  logic [WORD_W-1:0] mt_words [STATE_WORDS];
  int unsigned       mt_pos;
  logic [WORD_W-1:0] expected_words [$];

  beat_t       pending_beats [$];
  int unsigned beats_total;
  int unsigned beats_taken;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned mismatches;
  int unsigned reports;
  longint unsigned cycle_count;
  longint unsigned cycle_limit;
  bit          calm_phase;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned draw_wait();
    // flip between stretches with no idling and stretches with random gaps
    if ($urandom_range(0, 31) == 0) calm_phase = !calm_phase;
    return calm_phase ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic void push_beat(input logic action, input logic [WORD_W-1:0] seed,
                                    input bit drain);
    beat_t b;
    b.action = action;
    b.seed   = seed;
    b.drain  = drain;
    pending_beats.push_back(b);
    beats_total++;
    cycle_limit += (action == ACT_SEED) ? 4 * 2600 : 4 * 25;
  endfunction

  function automatic void push_run(input logic [WORD_W-1:0] seed, input int unsigned words,
                                   input bit drain);
    push_beat(ACT_SEED, seed, drain);
    for (int unsigned i = 0; i < words; i++) push_beat(ACT_NEXT, '0, 1'b0);
  endfunction

  // Advance the generator model by one accepted beat.
  task automatic mt_accept(input logic action, input logic [WORD_W-1:0] seed);
    logic [WORD_W-1:0] lcg;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] y;
    int unsigned       k;
    if (action == ACT_SEED) begin
      lcg = seed;
      for (k = 0; k < STATE_WORDS; k++) begin
        w   = lcg & 32'hffff_0000;
        lcg = lcg * LCG_MULT + LCG_INC;
        w   = w | (lcg >> HALF_W);
        lcg = lcg * LCG_MULT + LCG_INC;
        mt_words[k] = w;
      end
      mt_pos = STATE_WORDS;
    end else begin
      if (mt_pos >= STATE_WORDS) begin
        // twist in place: later words see the already updated early ones
        for (k = 0; k < STATE_WORDS; k++) begin
          y = {mt_words[k][WORD_W-1], mt_words[(k + 1) % STATE_WORDS][WORD_W-2:0]};
          w = mt_words[(k + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1);
          if (y[0]) w = w ^ TWIST_MATRIX;
          mt_words[k] = w;
        end
        mt_pos = 0;
      end
      y = mt_words[mt_pos];
      y = y ^ {11'b0, y[WORD_W-1:11]};
      y = y ^ ({y[WORD_W-8:0], 7'b0} & TEMPER_B);
      y = y ^ ({y[WORD_W-16:0], 15'b0} & TEMPER_C);
      y = y ^ {18'b0, y[WORD_W-1:18]};
      expected_words.push_back(y);
      mt_pos++;
    end
  endtask

  always @(posedge clk_i) begin : send_side
    beat_t b;
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      in_if.action <= ACT_SEED;
      in_if.seed   <= '0;
      send_gap     <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        mt_accept(in_if.action, in_if.seed);
        beats_taken++;
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the beat until taken
      end else if (send_gap != 0) begin
        in_if.valid <= 1'b0;
        send_gap    <= send_gap - 1;
      end else if (pending_beats.size() != 0 &&
                   !(pending_beats[0].drain && expected_words.size() != 0)) begin
        b = pending_beats.pop_front();
        in_if.valid  <= 1'b1;
        in_if.action <= b.action;
        in_if.seed   <= b.seed;
        send_gap     <= draw_wait();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : recv_side
    int unsigned      gap;
    logic [WORD_W-1:0] want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_stall   <= 0;
    end else if (out_if.valid && out_if.ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (reports++ < MAX_REPORTS)
          $error("random_word: expected none, actual %h", out_if.random_word);
      end else begin
        want = expected_words.pop_front();
        if (want !== out_if.random_word) begin
          mismatches++;
          if (reports++ < MAX_REPORTS)
            $error("random_word: expected %h, actual %h", want, out_if.random_word);
        end
      end
      gap = draw_wait();
      recv_stall   <= gap;
      out_if.ready <= (gap == 0);
    end else if (recv_stall != 0) begin
      recv_stall   <= recv_stall - 1;
      out_if.ready <= (recv_stall == 1);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= cycle_limit) begin
      $display("mersenne_twister_generator_unit verification failed");
      $finish;
    end
  end

  initial begin
    logic [WORD_W-1:0] seed;
    int unsigned       pick;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.action = ACT_SEED;
    in_if.seed   = '0;
    out_if.ready = 1'b0;
    cycle_count  = 0;
    cycle_limit  = 20000 + TAIL_CYCLES;
    beats_total  = 0;
    beats_taken  = 0;
    mismatches   = 0;
    reports      = 0;
    mt_pos       = STATE_WORDS;

    // directed: seed extremes, back-to-back seeds, reseed in mid-stream
    push_run(32'h0000_0000, 3, 1'b0);
    push_run(32'hffff_ffff, 2, 1'b0);
    push_run(32'd4357, 2, 1'b1);
    push_run(32'h8000_0000, 1, 1'b0);
    push_run(32'h0000_0001, 0, 1'b0);
    push_run(32'h7fff_ffff, 1, 1'b0);
    push_run(32'haaaa_aaaa, 2, 1'b0);
    push_run(32'h5555_5555, 2, 1'b1);

    // one long stream crosses the index wrap and a second twist
    push_run($urandom, LONG_RUN, 1'b1);

    while (beats_total < TARGET_BEATS) begin
      pick = $urandom_range(0, 15);
      case (pick)
        0:       seed = 32'h0000_0000;
        1:       seed = 32'hffff_ffff;
        2:       seed = 32'h8000_0000;
        3:       seed = 32'h7fff_ffff;
        default: seed = $urandom;
      endcase
      push_run(seed, $urandom_range(0, 24), $urandom_range(0, 19) == 0);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_taken != beats_total) @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
    // a trailing seed beat keeps the block busy without producing a word
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("mersenne_twister_generator_unit verification clean");
    end else begin
      $display("mersenne_twister_generator_unit verification failed");
    end
    $finish;
  end

endmodule
